FILE: hdl/solht_pkg.sv
//------------------------------------------------------------------------------
// solht_pkg
// Shared types and constants for the shape outline hit test.
//------------------------------------------------------------------------------
`default_nettype none
package solht_pkg;
	typedef enum logic [1:0] {
		FUNC_SEGMENT   = 2'd0,
		FUNC_CIRCLE    = 2'd1,
		FUNC_RECTANGLE = 2'd2,
		FUNC_TRIANGLE  = 2'd3
	} func_t;

	localparam int unsigned REG_PICK_THRESHOLD = 0;
	localparam logic [31:0] THRESHOLD_RESET = 32'd65536;
endpackage
`default_nettype wire

FILE: hdl/solht_if.sv
//------------------------------------------------------------------------------
// solht_query_if / solht_result_if
// Valid/ready channels for query and result transactions.
//------------------------------------------------------------------------------
`default_nettype none
interface solht_query_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic [1:0] func;
	logic signed [COORD_WIDTH-1:0] pick_x, pick_y, ax, ay, bx, by, cx, cy;
	logic [COORD_WIDTH-2:0] circle_radius;
	modport source (output valid, func, pick_x, pick_y, ax, ay, bx, by, cx, cy,
		circle_radius, input ready);
	modport sink (input valid, func, pick_x, pick_y, ax, ay, bx, by, cx, cy,
		circle_radius, output ready);
endinterface

interface solht_result_if;
	logic valid;
	logic ready;
	logic hit;
	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface
`default_nettype wire

FILE: hdl/solht_seg.sv
//------------------------------------------------------------------------------
// solht_seg
// Pipelined point-to-segment proximity test, one query per cycle while en is high, 5 stages.
//------------------------------------------------------------------------------
`default_nettype none
module solht_seg #(
	parameter int COORD_WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire signed [COORD_WIDTH-1:0] px, py, ax, ay, bx, by,
	input  wire        [COORD_WIDTH-2:0] thr,
	output logic                         hit
);
	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;
	localparam int TW = 2 * (COORD_WIDTH - 1);
	// halves of the cross magnitude and length (HW) and of the squared threshold (TH)
	localparam int HW = COORD_WIDTH + 1;
	localparam int TH = COORD_WIDTH - 1;
	localparam int QW = 4 * HW;

	// stage 1: differences
	logic signed [DW-1:0] ea_s1, eb_s1, ec_s1, ed_s1, fa_s1, fb_s1;
	logic        [COORD_WIDTH-2:0] t_s1;
	// stage 2: products
	logic signed [PW-1:0] ac_s2, bd_s2, cc_s2, dd_s2, ad_s2, bc_s2;
	logic signed [PW-1:0] aa_s2, bb_s2, ff_s2, gg_s2;
	logic        [TW-1:0] t2_s2;
	// stage 3: sums
	logic signed [SW-1:0] dot_s3, len_s3, cr_s3, da_s3, db_s3;
	logic        [TW-1:0] t2_s3;
	// stage 4: partial products of the cross square and threshold times length
	logic        [2*HW-1:0]    chh_s4, chl_s4, cll_s4;
	logic        [TH+HW-1:0]   thh_s4, thl_s4, tlh_s4, tll_s4;
	logic                      sel_a_s4, sel_b_s4, ha_s4, hb_s4;
	// stage 5: assembled wide terms
	logic        [QW-1:0]      cr2_s5, tl_s5;
	logic                      sel_a_s5, sel_b_s5, ha_s5, hb_s5;
	logic        [SW-1:0]      cru;
	logic        [HW-1:0]      cr_hi, cr_lo, ln_hi, ln_lo;
	logic        [TH-1:0]      t2_hi, t2_lo;

	assign cru = cr_s3[SW-1] ? SW'(-cr_s3) : SW'(cr_s3);
	assign cr_hi = cru[2*HW-1:HW];
	assign cr_lo = cru[HW-1:0];
	assign ln_hi = len_s3[2*HW-1:HW];
	assign ln_lo = len_s3[HW-1:0];
	assign t2_hi = t2_s3[TW-1:TH];
	assign t2_lo = t2_s3[TH-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ea_s1 <= DW'(px) - DW'(ax);
			eb_s1 <= DW'(py) - DW'(ay);
			ec_s1 <= DW'(bx) - DW'(ax);
			ed_s1 <= DW'(by) - DW'(ay);
			fa_s1 <= DW'(px) - DW'(bx);
			fb_s1 <= DW'(py) - DW'(by);
			t_s1  <= thr;

			ac_s2 <= PW'(ea_s1) * PW'(ec_s1);
			bd_s2 <= PW'(eb_s1) * PW'(ed_s1);
			cc_s2 <= PW'(ec_s1) * PW'(ec_s1);
			dd_s2 <= PW'(ed_s1) * PW'(ed_s1);
			ad_s2 <= PW'(ea_s1) * PW'(ed_s1);
			bc_s2 <= PW'(eb_s1) * PW'(ec_s1);
			aa_s2 <= PW'(ea_s1) * PW'(ea_s1);
			bb_s2 <= PW'(eb_s1) * PW'(eb_s1);
			ff_s2 <= PW'(fa_s1) * PW'(fa_s1);
			gg_s2 <= PW'(fb_s1) * PW'(fb_s1);
			t2_s2 <= TW'(t_s1) * TW'(t_s1);

			dot_s3 <= SW'(ac_s2) + SW'(bd_s2);
			len_s3 <= SW'(cc_s2) + SW'(dd_s2);
			cr_s3  <= SW'(ad_s2) - SW'(bc_s2);
			da_s3  <= SW'(aa_s2) + SW'(bb_s2);
			db_s3  <= SW'(ff_s2) + SW'(gg_s2);
			t2_s3  <= t2_s2;

			chh_s4   <= (2*HW)'(cr_hi) * (2*HW)'(cr_hi);
			chl_s4   <= (2*HW)'(cr_hi) * (2*HW)'(cr_lo);
			cll_s4   <= (2*HW)'(cr_lo) * (2*HW)'(cr_lo);
			thh_s4   <= (TH+HW)'(t2_hi) * (TH+HW)'(ln_hi);
			thl_s4   <= (TH+HW)'(t2_hi) * (TH+HW)'(ln_lo);
			tlh_s4   <= (TH+HW)'(t2_lo) * (TH+HW)'(ln_hi);
			tll_s4   <= (TH+HW)'(t2_lo) * (TH+HW)'(ln_lo);
			sel_a_s4 <= (len_s3 == '0) || dot_s3[SW-1];
			sel_b_s4 <= !dot_s3[SW-1] && (dot_s3 > len_s3);
			ha_s4    <= SW'(t2_s3) > da_s3;
			hb_s4    <= SW'(t2_s3) > db_s3;

			cr2_s5   <= (QW'(chh_s4) << (2*HW)) + (QW'(chl_s4) << (HW+1)) + QW'(cll_s4);
			tl_s5    <= (QW'(thh_s4) << (TH+HW)) + (QW'(thl_s4) << TH)
				+ (QW'(tlh_s4) << HW) + QW'(tll_s4);
			sel_a_s5 <= sel_a_s4;
			sel_b_s5 <= sel_b_s4;
			ha_s5    <= ha_s4;
			hb_s5    <= hb_s4;
		end
	end

	always_comb begin
		priority if (sel_a_s5) hit = ha_s5;
		else if (sel_b_s5)     hit = hb_s5;
		else                   hit = cr2_s5 < tl_s5;
	end

	logic unused_rst;
	assign unused_rst = arst_n;
endmodule
`default_nettype wire

FILE: hdl/solht_front.sv
//------------------------------------------------------------------------------
// solht_front
// Accept query transactions and hold them, with their shape kind, in a short queue.
//------------------------------------------------------------------------------
`default_nettype none
module solht_front #(
	parameter int COORD_WIDTH = 32,
	parameter int DEPTH       = 4
) (
	input  wire clk,
	input  wire arst_n,
	solht_query_if.sink in_q,
	input  wire                          pop,
	output logic                         avail,
	output logic [1:0]                   func,
	output logic signed [COORD_WIDTH-1:0] px, py, ax, ay, bx, by, cx, cy,
	output logic [COORD_WIDTH-2:0]       rad
);
	localparam int AW = $clog2(DEPTH);
	localparam int EW = 2 + 8 * COORD_WIDTH + COORD_WIDTH - 1;

	logic [EW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          push;
	logic [EW-1:0] head;

	assign in_q.ready = (cnt_q != (AW+1)'(DEPTH));
	assign push  = in_q.valid && in_q.ready;
	assign avail = (cnt_q != '0);
	assign head  = mem_q[rp_q];
	assign {func, px, py, ax, ay, bx, by, cx, cy, rad} = head;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= {in_q.func, in_q.pick_x, in_q.pick_y, in_q.ax, in_q.ay,
				in_q.bx, in_q.by, in_q.cx, in_q.cy, in_q.circle_radius};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

FILE: hdl/solht_back.sv
//------------------------------------------------------------------------------
// solht_back
// Pipelined shape evaluation with credit-based result buffer.
//------------------------------------------------------------------------------
`default_nettype none
module solht_back #(
	parameter int COORD_WIDTH = 32
) (
	input  wire clk,
	input  wire arst_n,
	input  wire                          avail,
	output logic                         pop,
	input  wire [1:0]                    func,
	input  wire signed [COORD_WIDTH-1:0] px, py, ax, ay, bx, by, cx, cy,
	input  wire [COORD_WIDTH-2:0]        rad,
	input  wire [COORD_WIDTH-2:0]        thr,
	solht_result_if.source out_r
);
	localparam int LAT = 5;
	localparam int OD  = 8;
	localparam int OAW = 3;
	localparam int DW  = COORD_WIDTH + 2;
	localparam int PW  = 2 * DW;

	logic [LAT-1:0] vld_q;
	logic [1:0]     fn_s1, fn_s2, fn_s3, fn_s4, fn_s5;
	logic           rect_s4, rect_s5;
	logic           h0, h1, h2;
	logic [OAW:0]   occ_q;
	logic [OD-1:0]  buf_q;
	logic [OAW-1:0] wp_q, rp_q;
	logic           res_hit;
	logic           out_pop;
	logic           inflight_ok;

	// Credit: buffer occupancy plus in-flight items must stay within OD.
	assign inflight_ok = (32'(occ_q) + 32'($countones(vld_q))) < OD;
	assign pop = avail && inflight_ok;

	solht_seg #(.COORD_WIDTH(COORD_WIDTH)) u_seg0 (.clk, .arst_n, .en(1'b1),
		.px, .py, .ax, .ay, .bx, .by, .thr, .hit(h0));
	solht_seg #(.COORD_WIDTH(COORD_WIDTH)) u_seg1 (.clk, .arst_n, .en(1'b1),
		.px, .py, .ax(bx), .ay(by), .bx(cx), .by(cy), .thr, .hit(h1));
	solht_seg #(.COORD_WIDTH(COORD_WIDTH)) u_seg2 (.clk, .arst_n, .en(1'b1),
		.px, .py, .ax(cx), .ay(cy), .bx(ax), .by(ay), .thr, .hit(h2));

	// circle path
	logic signed [DW-1:0] cdx_s1, cdy_s1, lo_s1, hi_s1;
	logic        [PW-1:0] d2a_s2, d2b_s2, hi2_s2, lo2_s2;
	logic                 neg_s2, neg_s3;
	logic        [PW:0]   d2_s3;
	logic        [PW-1:0] hi2_s3, lo2_s3;
	logic                 c_s4, c_s5;

	// rectangle path
	logic signed [DW-1:0] x0, x1, y0, y1, t_e, pxe, pye;
	logic                 r_s1, r_s2, r_s3;

	always_comb begin
		t_e = DW'(thr);
		pxe = DW'(px);
		pye = DW'(py);
		x0 = (ax < bx) ? DW'(ax) : DW'(bx);
		x1 = (ax < bx) ? DW'(bx) : DW'(ax);
		y0 = (ay < by) ? DW'(ay) : DW'(by);
		y1 = (ay < by) ? DW'(by) : DW'(ay);
	end

	function automatic logic near(input logic signed [DW-1:0] a, b, t);
		logic signed [DW-1:0] d;
		d = (a > b) ? a - b : b - a;
		return d < t;
	endfunction

	always_ff @(posedge clk) begin
		fn_s1 <= func; fn_s2 <= fn_s1; fn_s3 <= fn_s2; fn_s4 <= fn_s3; fn_s5 <= fn_s4;

		r_s1 <= ((near(pxe, x0, t_e) || near(pxe, x1, t_e))
				&& pye >= y0 - t_e && pye <= y1 + t_e)
			|| ((near(pye, y0, t_e) || near(pye, y1, t_e))
				&& pxe >= x0 - t_e && pxe <= x1 + t_e);
		r_s2 <= r_s1; r_s3 <= r_s2;
		rect_s4 <= r_s3;
		rect_s5 <= rect_s4;

		cdx_s1 <= DW'(px) - DW'(ax);
		cdy_s1 <= DW'(py) - DW'(ay);
		hi_s1  <= DW'(rad) + DW'(thr);
		lo_s1  <= DW'(rad) - DW'(thr);

		d2a_s2 <= PW'(cdx_s1) * PW'(cdx_s1);
		d2b_s2 <= PW'(cdy_s1) * PW'(cdy_s1);
		hi2_s2 <= PW'(hi_s1) * PW'(hi_s1);
		lo2_s2 <= PW'(lo_s1) * PW'(lo_s1);
		neg_s2 <= lo_s1[DW-1];

		d2_s3  <= (PW+1)'(d2a_s2) + (PW+1)'(d2b_s2);
		hi2_s3 <= hi2_s2;
		lo2_s3 <= lo2_s2;
		neg_s3 <= neg_s2;

		c_s4   <= (d2_s3 < (PW+1)'(hi2_s3)) && (neg_s3 || ((PW+1)'(lo2_s3) < d2_s3));
		c_s5   <= c_s4;
	end

	always_comb begin
		unique case (solht_pkg::func_t'(fn_s5))
			solht_pkg::FUNC_SEGMENT:   res_hit = h0;
			solht_pkg::FUNC_CIRCLE:    res_hit = c_s5;
			solht_pkg::FUNC_RECTANGLE: res_hit = rect_s5;
			solht_pkg::FUNC_TRIANGLE:  res_hit = h0 || h1 || h2;
			default:                   res_hit = 1'b0;
		endcase
	end

	assign out_pop     = out_r.valid && out_r.ready;
	assign out_r.valid = (occ_q != '0);
	assign out_r.hit   = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			occ_q <= '0;
			wp_q  <= '0;
			rp_q  <= '0;
			buf_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], pop};
			if (vld_q[LAT-1]) begin
				buf_q[wp_q] <= res_hit;
				wp_q <= wp_q + 1'b1;
			end
			if (out_pop) rp_q <= rp_q + 1'b1;
			occ_q <= occ_q + (OAW+1)'(vld_q[LAT-1]) - (OAW+1)'(out_pop);
		end
	end
endmodule
`default_nettype wire

FILE: hdl/shape_outline_hit_test.sv
//------------------------------------------------------------------------------
// shape_outline_hit_test
// Decide whether a pick point lies within the threshold of a shape outline.
//------------------------------------------------------------------------------
// One query transaction (pick point plus a segment, circle, rectangle or
// triangle) yields one result transaction carrying hit. Queries are taken one
// per cycle while the input queue has room, so the rate is one item per cycle
// when neither side stalls, set by the fully pipelined evaluation unit (three
// segment testers, circle and rectangle paths side by side). A four-entry input
// queue and an eight-entry result buffer let either side stall on its own.
// Segment and circle tests are exact on squared distances, rectangle tests on
// plain gaps. pick_threshold sits at byte address 0 of the APB-style port.
`default_nettype none
module shape_outline_hit_test #(
	parameter int COORD_WIDTH = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [1:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	solht_query_if.sink    query,
	solht_result_if.source result
);
	logic [COORD_WIDTH-2:0] thr_q;
	logic                   avail, pop;
	logic [1:0]             func;
	logic signed [COORD_WIDTH-1:0] px, py, ax, ay, bx, by, cx, cy;
	logic [COORD_WIDTH-2:0] rad;

	assign pready = 1'b1;

	// Register write: take the threshold on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= (COORD_WIDTH-1)'(solht_pkg::THRESHOLD_RESET);
		end else if (psel && penable && pwrite
				&& paddr == 2'(solht_pkg::REG_PICK_THRESHOLD * 4)) begin
			thr_q <= (COORD_WIDTH-1)'(pwdata);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == 2'(solht_pkg::REG_PICK_THRESHOLD * 4)) prdata = 32'(thr_q);
	end

	solht_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk, .arst_n, .in_q(query), .pop, .avail, .func,
		.px, .py, .ax, .ay, .bx, .by, .cx, .cy, .rad);

	solht_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk, .arst_n, .avail, .pop, .func,
		.px, .py, .ax, .ay, .bx, .by, .cx, .cy, .rad, .thr(thr_q), .out_r(result));
endmodule
`default_nettype wire

FILE: hdl/solht_checker.sv
//------------------------------------------------------------------------------
// solht_checker
// Port-level checks for the shape outline hit test.
//------------------------------------------------------------------------------
`default_nettype none
module solht_checker (
	input wire clk,
	input wire arst_n,
	input wire pready,
	input wire q_valid,
	input wire q_ready,
	input wire r_valid,
	input wire r_ready,
	input wire r_hit
);
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_hit))
		else $error("result dropped");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(r_valid) && !$isunknown(q_ready))
		else $error("handshake unknown");
	a_hit_known: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> !$isunknown(r_hit))
		else $error("result hit unknown");
	a_q_hold: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !q_ready |=> q_valid)
		else $error("query withdrawn");
endmodule

bind shape_outline_hit_test solht_checker u_chk (
	.clk, .arst_n, .pready, .q_valid(query.valid), .q_ready(query.ready),
	.r_valid(result.valid), .r_ready(result.ready), .r_hit(result.hit));
`default_nettype wire

FILE: bench/tb_shape_outline_hit_test.sv
//------------------------------------------------------------------------------
// tb_shape_outline_hit_test
// Self-checking bench for the shape outline hit test: directed corner cases,
// then random shapes with picks placed around their outlines, under several
// thresholds and source/sink idling patterns; every result is checked against
// an exact wide-integer model of the hit decision.
//------------------------------------------------------------------------------
`default_nettype none
module tb_shape_outline_hit_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [255:0] wide_t;
	typedef struct {
		solht_pkg::func_t   kind;
		logic signed [31:0] px, py, ax, ay, bx, by, cx, cy;
		logic [30:0]       radius;
	} query_t;

	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	solht_query_if #(.COORD_WIDTH(32)) query ();
	solht_result_if                    result ();

	// Current tolerance as the block holds it, and the hits still to arrive
	logic [30:0] threshold = solht_pkg::THRESHOLD_RESET[30:0];
	bit          hit_expected_q[$];
	int          error_count = 0;
	int          src_idle_pct = 0, snk_idle_pct = 0;
	int          stall_cycles = 0;

	shape_outline_hit_test #(.COORD_WIDTH(32)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.query(query), .result(result)
	);

	always #5 clk = ~clk;

	initial begin
		query.valid = 1'b0;
		query.func = solht_pkg::FUNC_SEGMENT;
		{query.pick_x, query.pick_y, query.ax, query.ay} = '0;
		{query.bx, query.by, query.cx, query.cy} = '0;
		query.circle_radius = '0;
		result.ready = 1'b0;
	end

	//--------------------------------------------------------------------------
	// Exact hit model: all squared quantities carried in 256-bit signed
	//--------------------------------------------------------------------------
	function automatic bit segment_near(longint px, longint py, longint ax, longint ay,
			longint bx, longint by, longint t);
		wide_t ea, eb, ec, ed, fa, fb, t2, dot, len2, cr;
		ea = px - ax; eb = py - ay; ec = bx - ax; ed = by - ay;
		fa = px - bx; fb = py - by;
		t2 = wide_t'(t) * wide_t'(t);
		dot = ea * ec + eb * ed;
		len2 = ec * ec + ed * ed;
		// zero-length segment or foot behind the start: measure to the start
		if (len2 == 0 || dot < 0)
			return (ea * ea + eb * eb) < t2;
		// foot beyond the end: measure to the end
		if (len2 < dot)
			return (fa * fa + fb * fb) < t2;
		cr = ea * ed - eb * ec;
		return (cr * cr) < (t2 * len2);
	endfunction

	function automatic bit circle_near(longint px, longint py, longint ax, longint ay,
			longint r, longint t);
		wide_t dx, dy, d2, hi, lo;
		dx = px - ax; dy = py - ay;
		d2 = dx * dx + dy * dy;
		hi = r + t;
		lo = r - t;
		if (!(d2 < hi * hi))
			return 1'b0;
		// radius below the tolerance: the inner bound always holds
		if (lo < 0)
			return 1'b1;
		return (lo * lo) < d2;
	endfunction

	function automatic longint abs_gap(longint a, longint b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic bit rectangle_near(longint px, longint py, longint ax, longint ay,
			longint bx, longint by, longint t);
		longint x0, x1, y0, y1;
		bit on_vert, on_horz;
		x0 = (ax < bx) ? ax : bx; x1 = (ax < bx) ? bx : ax;
		y0 = (ay < by) ? ay : by; y1 = (ay < by) ? by : ay;
		on_vert = (abs_gap(px, x0) < t || abs_gap(px, x1) < t)
			&& py >= y0 - t && py <= y1 + t;
		on_horz = (abs_gap(py, y0) < t || abs_gap(py, y1) < t)
			&& px >= x0 - t && px <= x1 + t;
		return on_vert || on_horz;
	endfunction

	function automatic bit predict_hit(query_t q);
		longint t;
		t = longint'(threshold);
		case (q.kind)
			solht_pkg::FUNC_SEGMENT:
				return segment_near(q.px, q.py, q.ax, q.ay, q.bx, q.by, t);
			solht_pkg::FUNC_CIRCLE:
				return circle_near(q.px, q.py, q.ax, q.ay, longint'(q.radius), t);
			solht_pkg::FUNC_RECTANGLE:
				return rectangle_near(q.px, q.py, q.ax, q.ay, q.bx, q.by, t);
			default:
				return segment_near(q.px, q.py, q.ax, q.ay, q.bx, q.by, t)
					|| segment_near(q.px, q.py, q.bx, q.by, q.cx, q.cy, t)
					|| segment_near(q.px, q.py, q.cx, q.cy, q.ax, q.ay, t);
		endcase
	endfunction

	//--------------------------------------------------------------------------
	// Result side: random back-pressure, check at the falling edge
	//--------------------------------------------------------------------------
	task automatic report_mismatch(string what, int want, int got);
		error_count++;
		$display("mismatch %0t: %s expected %0d got %0d", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n)
			result.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// ready and valid are stable from negedge to the next edge, so sample here
	always @(negedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			if (hit_expected_q.size() == 0)
				report_mismatch("unexpected result, hit", -1, result.hit);
			else if (hit_expected_q.pop_front() != result.hit)
				report_mismatch("hit", !result.hit, result.hit);
		end
	end

	// Watchdog: count cycles where neither channel moves a transaction
	always @(negedge clk) begin
		if ((query.valid && query.ready) || (result.valid && result.ready))
			stall_cycles <= 0;
		else if (hit_expected_q.size() != 0 || query.valid)
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("[shape_outline_hit_test] ERROR");
			$finish;
		end
	end

	//--------------------------------------------------------------------------
	// Query side
	//--------------------------------------------------------------------------
	// Send one transaction; enter and leave aligned to a rising edge
	task automatic send_query(query_t q);
		bit taken;
		while ($urandom_range(99) < src_idle_pct) begin
			query.valid <= 1'b0;
			@(posedge clk);
		end
		query.valid <= 1'b1;
		query.func <= q.kind;
		query.pick_x <= q.px; query.pick_y <= q.py;
		query.ax <= q.ax; query.ay <= q.ay;
		query.bx <= q.bx; query.by <= q.by;
		query.cx <= q.cx; query.cy <= q.cy;
		query.circle_radius <= q.radius;
		do begin
			@(negedge clk);
			taken = query.ready;
			@(posedge clk);
		end while (!taken);
		hit_expected_q.insert(hit_expected_q.size(), predict_hit(q));
	endtask

	// Hold off until every result is back, then let the pipeline settle
	task automatic drain_results();
		query.valid <= 1'b0;
		while (hit_expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_threshold(logic [31:0] value);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 2'(solht_pkg::REG_PICK_THRESHOLD * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		threshold = value[30:0];
		@(posedge clk);
	endtask

	// Random offset in [-m, m]
	function automatic longint jitter(longint m);
		return longint'($urandom_range(0, 32'(2 * m))) - m;
	endfunction

	// Build a shape with the pick placed near its outline, or pure noise
	function automatic query_t random_query();
		query_t q;
		longint t, span, k, ax, ay, bx, by, cx, cy, px, py, r, tgt_x0, tgt_y0, tgt_x1,
			tgt_y1;
		q.kind = solht_pkg::func_t'($urandom_range(3));
		q.px = $urandom; q.py = $urandom; q.ax = $urandom; q.ay = $urandom;
		q.bx = $urandom; q.by = $urandom; q.cx = $urandom; q.cy = $urandom;
		q.radius = 31'($urandom);
		if ($urandom_range(9) == 0)
			return q;
		t = (threshold == 0) ? 64'd65536 : longint'(threshold);
		if (t > (64'd1 << 26))
			t = 64'd1 << 26;
		span = t * $urandom_range(1, 16);
		ax = longint'(q.ax) / 4;
		ay = longint'(q.ay) / 4;
		bx = ax + jitter(span); by = ay + jitter(span);
		cx = ax + jitter(span); cy = ay + jitter(span);
		if ($urandom_range(7) == 0) begin
			bx = ax; by = ay;
		end
		r = longint'($urandom_range(0, 32'(span)));
		k = $urandom_range(0, 16);
		case ($urandom_range(2))
			0: begin tgt_x0 = ax; tgt_y0 = ay; tgt_x1 = bx; tgt_y1 = by; end
			1: begin tgt_x0 = bx; tgt_y0 = by; tgt_x1 = cx; tgt_y1 = cy; end
			default: begin tgt_x0 = cx; tgt_y0 = cy; tgt_x1 = ax; tgt_y1 = ay; end
		endcase
		if (q.kind == solht_pkg::FUNC_RECTANGLE && $urandom_range(1))
			tgt_x1 = tgt_x0;
		px = tgt_x0 + (tgt_x1 - tgt_x0) * k / 16 + jitter(2 * t);
		py = tgt_y0 + (tgt_y1 - tgt_y0) * k / 16 + jitter(2 * t);
		if (q.kind == solht_pkg::FUNC_CIRCLE) begin
			px = ax + ($urandom_range(1) ? r : -r) + jitter(2 * t);
			py = ay + jitter(2 * t);
			if ($urandom_range(1)) begin
				k = px - ax; px = ax + (py - ay); py = ay + k;
			end
		end
		q.px = 32'(px); q.py = 32'(py);
		q.ax = 32'(ax); q.ay = 32'(ay);
		q.bx = 32'(bx); q.by = 32'(by);
		q.cx = 32'(cx); q.cy = 32'(cy);
		if (q.kind == solht_pkg::FUNC_CIRCLE)
			q.radius = 31'(r);
		return q;
	endfunction

	function automatic query_t shape(solht_pkg::func_t kind, longint px, longint py,
			longint ax, longint ay, longint bx, longint by, longint cx, longint cy,
			longint r);
		query_t q;
		q.kind = kind;
		q.px = 32'(px); q.py = 32'(py); q.ax = 32'(ax); q.ay = 32'(ay);
		q.bx = 32'(bx); q.by = 32'(by); q.cx = 32'(cx); q.cy = 32'(cy);
		q.radius = 31'(r);
		return q;
	endfunction

	//--------------------------------------------------------------------------
	// Tests
	//--------------------------------------------------------------------------
	localparam longint ONE = 64'd65536;
	localparam longint CMIN = -64'sd2147483648;
	localparam longint CMAX = 64'sd2147483647;

	// Reset tolerance of 1.0: each shape kind with hits and near misses
	task automatic test_directed_shapes();
		// segment: foot in the middle, past the end, behind the start
		send_query(shape(solht_pkg::FUNC_SEGMENT, 5*ONE, ONE/2, 0, 0, 10*ONE, 0, 7, 9, 3));
		send_query(shape(solht_pkg::FUNC_SEGMENT, 5*ONE, ONE, 0, 0, 10*ONE, 0, 0, 0, 0));
		send_query(shape(solht_pkg::FUNC_SEGMENT, 10*ONE+ONE/2, ONE/2, 0, 0, 10*ONE, 0,
			0, 0, 0));
		send_query(shape(solht_pkg::FUNC_SEGMENT, -ONE, 0, 0, 0, 10*ONE, 0, 0, 0, 0));
		send_query(shape(solht_pkg::FUNC_SEGMENT, -ONE+1, 0, 0, 0, 10*ONE, 0, 0, 0, 0));
		// zero-length segment, measured to its start
		send_query(shape(solht_pkg::FUNC_SEGMENT, 3*ONE, ONE/2, 3*ONE, 0, 3*ONE, 0,
			0, 0, 0));
		// extreme coordinates
		send_query(shape(solht_pkg::FUNC_SEGMENT, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX,
			0, 0, 0));
		send_query(shape(solht_pkg::FUNC_SEGMENT, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN,
			CMAX, CMAX, 64'h7fffffff));
		// circle: on the ring, inside, outside, radius below the tolerance
		send_query(shape(solht_pkg::FUNC_CIRCLE, 5*ONE, 0, 0, 0, 0, 0, 0, 0, 5*ONE));
		send_query(shape(solht_pkg::FUNC_CIRCLE, 2*ONE, 0, 0, 0, 1, 1, 1, 1, 5*ONE));
		send_query(shape(solht_pkg::FUNC_CIRCLE, 6*ONE, 0, 0, 0, 0, 0, 0, 0, 5*ONE));
		send_query(shape(solht_pkg::FUNC_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, ONE/2));
		send_query(shape(solht_pkg::FUNC_CIRCLE, CMAX, CMAX, CMIN, CMIN, 0, 0, 0, 0,
			64'h7fffffff));
		// rectangle: corners swapped, on edges, inside, outside
		send_query(shape(solht_pkg::FUNC_RECTANGLE, 10*ONE, 5*ONE, 10*ONE, 10*ONE, 0, 0,
			0, 0, 0));
		send_query(shape(solht_pkg::FUNC_RECTANGLE, 5*ONE, 5*ONE, 10*ONE, 10*ONE, 0, 0,
			0, 0, 0));
		send_query(shape(solht_pkg::FUNC_RECTANGLE, 11*ONE-1, 11*ONE, 0, 0, 10*ONE,
			10*ONE, 0, 0, 0));
		send_query(shape(solht_pkg::FUNC_RECTANGLE, 11*ONE, 5*ONE, 0, 0, 10*ONE, 10*ONE,
			0, 0, 0));
		send_query(shape(solht_pkg::FUNC_RECTANGLE, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX,
			0, 0, 0));
		// triangle: near each edge, then well inside
		send_query(shape(solht_pkg::FUNC_TRIANGLE, 5*ONE, 0, 0, 0, 10*ONE, 0, 0, 10*ONE,
			0));
		send_query(shape(solht_pkg::FUNC_TRIANGLE, 5*ONE, 5*ONE, 0, 0, 10*ONE, 0, 0,
			10*ONE, 0));
		send_query(shape(solht_pkg::FUNC_TRIANGLE, 0, 5*ONE, 0, 0, 10*ONE, 0, 0, 10*ONE,
			0));
		send_query(shape(solht_pkg::FUNC_TRIANGLE, 2*ONE, 2*ONE, 0, 0, 10*ONE, 0, 0,
			10*ONE, 0));
		drain_results();
	endtask

	// Zero tolerance: nothing may hit, even points on the outline
	task automatic test_zero_threshold();
		write_threshold(32'd0);
		send_query(shape(solht_pkg::FUNC_SEGMENT, 0, 0, 0, 0, ONE, 0, 0, 0, 0));
		send_query(shape(solht_pkg::FUNC_CIRCLE, ONE, 0, 0, 0, 0, 0, 0, 0, ONE));
		send_query(shape(solht_pkg::FUNC_RECTANGLE, 0, 0, 0, 0, ONE, ONE, 0, 0, 0));
		send_query(shape(solht_pkg::FUNC_TRIANGLE, 0, 0, 0, 0, ONE, 0, 0, ONE, 0));
		repeat (40) send_query(random_query());
		drain_results();
	endtask

	// Largest tolerance, with every register bit set in the write
	task automatic test_max_threshold();
		write_threshold(32'hffffffff);
		send_query(shape(solht_pkg::FUNC_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, 64'h7fffffff));
		send_query(shape(solht_pkg::FUNC_SEGMENT, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN,
			0, 0, 0));
		repeat (40) send_query(random_query());
		drain_results();
	endtask

	task automatic test_random_shapes(int count, logic [31:0] tol, int src_pct, int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		write_threshold(tol);
		repeat (count) begin
			send_query(random_query());
			// occasional bursts with no idling at all
			if ($urandom_range(49) == 0) begin
				src_idle_pct = 0;
				repeat (20) send_query(random_query());
				src_idle_pct = src_pct;
			end
		end
		drain_results();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_shapes();
		test_zero_threshold();
		test_max_threshold();
		test_random_shapes(320, 32'd65536, 14, 61);
		test_random_shapes(320, 32'd1 + $urandom_range(0, 32'h00ffffff), 61, 14);
		test_random_shapes(320, 32'd300, 0, 0);
		test_random_shapes(70, $urandom, 0, 0);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("[shape_outline_hit_test] OK");
		else
			$display("[shape_outline_hit_test] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
